// ----- src/s20m_pkg.sv -----
package s20m_pkg;

    localparam int DOUBLE_ROUNDS = 4;
    localparam int N_STEPS = 8 * DOUBLE_ROUNDS;
    localparam int LATENCY = N_STEPS + 3;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_01 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_23 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_4 = 8'd2;

    typedef logic [31:0] t_word;
    typedef t_word [15:0] t_state;
    typedef t_word [4:0] t_feed;

    typedef struct packed {
        logic       row;
        logic [1:0] idx;
    } t_step;

    localparam logic [3:0] SALSA_POS [16] = '{
        4'd12, 4'd8, 4'd4, 4'd0, 4'd13, 4'd9, 4'd5, 4'd1,
        4'd14, 4'd10, 4'd6, 4'd2, 4'd15, 4'd11, 4'd7, 4'd3
    };

    function automatic logic [3:0] qr_pos(input logic row, input logic [1:0] q,
                                          input logic [1:0] p);
        logic [15:0] quad;
        if (!row) begin
            unique case (q)
                2'd0: quad = {4'd12, 4'd8, 4'd4, 4'd0};
                2'd1: quad = {4'd1, 4'd13, 4'd9, 4'd5};
                2'd2: quad = {4'd6, 4'd2, 4'd14, 4'd10};
                default: quad = {4'd11, 4'd7, 4'd3, 4'd15};
            endcase
        end else begin
            unique case (q)
                2'd0: quad = {4'd3, 4'd2, 4'd1, 4'd0};
                2'd1: quad = {4'd4, 4'd7, 4'd6, 4'd5};
                2'd2: quad = {4'd9, 4'd8, 4'd11, 4'd10};
                default: quad = {4'd14, 4'd13, 4'd12, 4'd15};
            endcase
        end
        return quad[p*4 +: 4];
    endfunction

    function automatic t_word rotl_step(input t_word v, input logic [1:0] idx);
        t_word r;
        unique case (idx)
            2'd0: r = {v[24:0], v[31:25]};
            2'd1: r = {v[22:0], v[31:23]};
            2'd2: r = {v[18:0], v[31:19]};
            default: r = {v[13:0], v[31:14]};
        endcase
        return r;
    endfunction

endpackage

// ----- src/s20m_step.sv -----
module s20m_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  s20m_pkg::t_step   i_step,
    input  logic              i_vld,
    input  s20m_pkg::t_state  i_x,
    input  s20m_pkg::t_feed   i_w,
    output logic              o_vld,
    output s20m_pkg::t_state  o_x,
    output s20m_pkg::t_feed   o_w
);

    logic             r_vld;
    s20m_pkg::t_state r_x;
    s20m_pkg::t_feed  r_w;
    s20m_pkg::t_state n_x;

    always_comb begin
        logic [3:0] dst;
        logic [3:0] s1;
        logic [3:0] s2;
        n_x = i_x;
        for (int q = 0; q < 4; q++) begin
            dst = s20m_pkg::qr_pos(i_step.row, 2'(q), i_step.idx + 2'd1);
            s1 = s20m_pkg::qr_pos(i_step.row, 2'(q), i_step.idx);
            s2 = s20m_pkg::qr_pos(i_step.row, 2'(q), i_step.idx - 2'd1);
            n_x[dst] = i_x[dst] ^ s20m_pkg::rotl_step(i_x[s1] + i_x[s2], i_step.idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_w <= i_w;
    end

    assign o_vld = r_vld;
    assign o_x = r_x;
    assign o_w = r_w;

endmodule

// ----- src/s20m_feedfwd.sv -----
module s20m_feedfwd (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  s20m_pkg::t_state  i_x,
    input  s20m_pkg::t_feed   i_w,
    input  s20m_pkg::t_feed   i_tgt,
    output logic              o_vld,
    output s20m_pkg::t_feed   o_sum,
    output logic              o_match
);

    logic            r_vld1;
    logic            r_vld2;
    s20m_pkg::t_feed r_sum;
    s20m_pkg::t_feed r_out;
    logic            r_match;
    s20m_pkg::t_feed n_sum;
    logic            n_match;

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            n_sum[k] = i_w[k] + i_x[s20m_pkg::SALSA_POS[k]];
        end
    end

    always_comb begin
        n_match = 1'b1;
        for (int k = 0; k < 5; k++) begin
            if (r_sum[k] != i_tgt[k]) begin
                n_match = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
        r_out <= r_sum;
        r_match <= n_match;
    end

    assign o_vld = r_vld2;
    assign o_sum = r_out;
    assign o_match = r_match;

endmodule

// ----- src/salsa20_8_truncated_match.sv -----
// Truncated Salsa20 core with a target match, for brute-force candidate search.
// A transaction starts at a rising edge where start is high and busy is low; the
// eight 64-bit pairs carry the sixteen state words, low word first in each pair.
// The block runs a fixed number of double rounds, adds input words 0 to 4 back in
// and compares the five sums with the target registers.
// The result of a start transaction appears with o_valid high for one cycle.
// Each quarter-round step (one add, rotate and xor on all four quarters at
// once) has a pipeline register of its own, followed by an input register
// ahead and two feed-forward stages behind.
// One new candidate is taken every cycle while busy is low; items never wait
// on each other. The receiver cannot stall, so results leave in the cycle
// they are made.
// Reset is synchronous and active low: it clears all valid bits and the three
// target registers, and busy is high during the cycle after reset.
// Target registers are written over the configuration channel, which is always
// ready; index 0 and 1 take 64 bits, index 2 takes the low 32 bits, other
// indexes are ignored. Targets should only change while no item is in flight.
module salsa20_8_truncated_match (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [63:0]                      i_in_pair_0,
    input  logic [63:0]                      i_in_pair_1,
    input  logic [63:0]                      i_in_pair_2,
    input  logic [63:0]                      i_in_pair_3,
    input  logic [63:0]                      i_in_pair_4,
    input  logic [63:0]                      i_in_pair_5,
    input  logic [63:0]                      i_in_pair_6,
    input  logic [63:0]                      i_in_pair_7,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [s20m_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [63:0]                      i_cfg_data,
    output logic                             o_valid,
    output logic [31:0]                      o_out_word_0,
    output logic [31:0]                      o_out_word_1,
    output logic [31:0]                      o_out_word_2,
    output logic [31:0]                      o_out_word_3,
    output logic [31:0]                      o_out_word_4,
    output logic                             o_all_match
);

    localparam int NS = s20m_pkg::N_STEPS;

    logic             r_busy;
    logic [63:0]      r_tgt01;
    logic [63:0]      r_tgt23;
    logic [31:0]      r_tgt4;
    logic             r_vld0;
    s20m_pkg::t_state r_x0;
    s20m_pkg::t_feed  r_w0;

    s20m_pkg::t_word  in_w [16];
    s20m_pkg::t_state n_x0;
    logic             accept;

    logic             st_vld [NS+1];
    s20m_pkg::t_state st_x [NS+1];
    s20m_pkg::t_feed  st_w [NS+1];

    s20m_pkg::t_feed  tgt;
    s20m_pkg::t_feed  sum;

    assign accept = start && !busy;
    assign busy = r_busy;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        in_w[0] = i_in_pair_0[31:0];   in_w[1] = i_in_pair_0[63:32];
        in_w[2] = i_in_pair_1[31:0];   in_w[3] = i_in_pair_1[63:32];
        in_w[4] = i_in_pair_2[31:0];   in_w[5] = i_in_pair_2[63:32];
        in_w[6] = i_in_pair_3[31:0];   in_w[7] = i_in_pair_3[63:32];
        in_w[8] = i_in_pair_4[31:0];   in_w[9] = i_in_pair_4[63:32];
        in_w[10] = i_in_pair_5[31:0];  in_w[11] = i_in_pair_5[63:32];
        in_w[12] = i_in_pair_6[31:0];  in_w[13] = i_in_pair_6[63:32];
        in_w[14] = i_in_pair_7[31:0];  in_w[15] = i_in_pair_7[63:32];
        for (int k = 0; k < 16; k++) begin
            n_x0[s20m_pkg::SALSA_POS[k]] = in_w[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld0 <= 1'b0;
            r_tgt01 <= '0;
            r_tgt23 <= '0;
            r_tgt4 <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld0 <= accept;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    s20m_pkg::REG_TGT_01: r_tgt01 <= i_cfg_data;
                    s20m_pkg::REG_TGT_23: r_tgt23 <= i_cfg_data;
                    s20m_pkg::REG_TGT_4:  r_tgt4 <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x0 <= n_x0;
        for (int k = 0; k < 5; k++) begin
            r_w0[k] <= in_w[k];
        end
    end

    assign st_vld[0] = r_vld0;
    assign st_x[0] = r_x0;
    assign st_w[0] = r_w0;

    for (genvar g = 0; g < NS; g++) begin : g_step
        localparam s20m_pkg::t_step STEP = '{row: 1'((g / 4) % 2), idx: 2'(g % 4)};
        s20m_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (STEP),
            .i_vld   (st_vld[g]),
            .i_x     (st_x[g]),
            .i_w     (st_w[g]),
            .o_vld   (st_vld[g+1]),
            .o_x     (st_x[g+1]),
            .o_w     (st_w[g+1])
        );
    end

    assign tgt[0] = r_tgt01[31:0];
    assign tgt[1] = r_tgt01[63:32];
    assign tgt[2] = r_tgt23[31:0];
    assign tgt[3] = r_tgt23[63:32];
    assign tgt[4] = r_tgt4;

    s20m_feedfwd u_feedfwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (st_vld[NS]),
        .i_x     (st_x[NS]),
        .i_w     (st_w[NS]),
        .i_tgt   (tgt),
        .o_vld   (o_valid),
        .o_sum   (sum),
        .o_match (o_all_match)
    );

    assign o_out_word_0 = sum[0];
    assign o_out_word_1 = sum[1];
    assign o_out_word_2 = sum[2];
    assign o_out_word_3 = sum[3];
    assign o_out_word_4 = sum[4];

    a_valid_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, s20m_pkg::LATENCY))
        else $error("result strobe without a matching start transaction");

    a_start_gives_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(s20m_pkg::LATENCY) o_valid)
        else $error("start transaction produced no result");

    a_reset_flushes: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid && !st_vld[0] && busy)
        else $error("pipeline not flushed by reset");

endmodule
